// File: sv/steered_response_power_spectrum_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the steered response power block
// Shared property forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef STEERED_RESPONSE_POWER_SPECTRUM_TOP_DEFINES_SVH
`define STEERED_RESPONSE_POWER_SPECTRUM_TOP_DEFINES_SVH

// Same-cycle implication
`define SRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Payload types, register indexes and fixed constants of the block.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int MaxResults = 64;
  localparam int DivSteps   = 56;
  localparam int SqrtSteps  = 28;

  localparam logic [39:0] SpecMax = 40'hFF_FFFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_CHANS = 2'd1;
  localparam logic [1:0] CFG_FIRST = 2'd2;
  localparam logic [1:0] CFG_COUNT = 2'd3;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         angle;
    logic [8:0]         bin;
    logic [2:0]         channel;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic [39:0]        energy;
  } srp_in_t;

  typedef struct packed {
    logic [5:0]  out_angle;
    logic [39:0] spectrum;
    logic        zero_energy;
    logic        last;
  } srp_out_t;

  // Request to the divide / square root unit
  typedef struct packed {
    logic        start;
    logic [55:0] num;
    logic [39:0] den;
  } srp_ds_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srp_ds_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_PWR,
    S_FIN,
    S_NORM,
    S_OUT
  } srp_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } srp_ds_state_e;

endpackage

// File: sv/srp_coef_ram.sv
// ----------------------------------------------------------------------------
// srp_coef_ram
// Steering coefficient memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srp_coef_ram #(
  parameter int Depth = 131584,
  parameter int AddrW = 18
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rd_data_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/srp_divsqrt.sv
// ----------------------------------------------------------------------------
// srp_divsqrt
// Restoring divide then digit-by-digit square root on one shared subtractor.
// ----------------------------------------------------------------------------
module srp_divsqrt
  import srp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  srp_ds_req_t  req_i,
  output srp_ds_stat_t stat_o,
  output logic [27:0]  root_o
);

  srp_ds_state_e state_q, state_d;
  logic [5:0]  cnt_q;
  logic [40:0] rem_q;
  logic [55:0] work_q;
  logic [39:0] den_q;
  logic [27:0] root_q;

  logic [40:0] sub_a, sub_b;
  logic [41:0] diff;
  logic        ge;
  logic        cnt_end;

  // Shared compare and subtract
  always_comb begin
    if (state_q == DS_SQRT) begin
      sub_a = {rem_q[38:0], work_q[55:54]};
      sub_b = {11'd0, root_q, 2'b01};
    end else begin
      sub_a = {rem_q[39:0], work_q[55]};
      sub_b = {1'b0, den_q};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[41];
  end

  assign cnt_end = (cnt_q == 6'd1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DS_IDLE: if (req_i.start) state_d = DS_DIV;
      DS_DIV:  if (cnt_end) state_d = DS_SQRT;
      DS_SQRT: if (cnt_end) state_d = DS_DONE;
      DS_DONE: state_d = DS_IDLE;
      default: state_d = DS_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat_o.busy = (state_q != DS_IDLE);
    stat_o.done = (state_q == DS_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DS_IDLE && req_i.start) begin
        cnt_q <= 6'(DivSteps);
      end else if (state_q == DS_DIV && cnt_end) begin
        cnt_q <= 6'(SqrtSteps);
      end else if (state_q == DS_DIV || state_q == DS_SQRT) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Advance the datapath one digit a cycle
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DS_IDLE: begin
        rem_q  <= '0;
        root_q <= '0;
        work_q <= req_i.num;
        den_q  <= req_i.den;
      end
      DS_DIV: begin
        rem_q  <= ge ? diff[40:0] : sub_a;
        work_q <= {work_q[54:0], ge};
        if (cnt_end) begin
          rem_q <= '0;
        end
      end
      DS_SQRT: begin
        rem_q  <= ge ? diff[40:0] : sub_a;
        root_q <= {root_q[26:0], ge};
        work_q <= {work_q[53:0], 2'b00};
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign root_o = root_q;

endmodule

// File: sv/steered_response_power_spectrum_top.sv
// ----------------------------------------------------------------------------
// steered_response_power_spectrum_top
// Delay-and-sum steered response power per angle from per-channel FFT bins.
// ----------------------------------------------------------------------------
// Coefficient loads and non-final channel samples are taken while idle. The
// sample for the last channel of a bin starts the sweep: for each angle and
// channel, one coefficient memory read then four products on the single
// shared multiplier; then the power is formed and the beat presented. In
// normalized mode with nonzero energy, a divide and a square root, one bit a
// cycle on the shared subtractor, and a done state come before the beat. The
// input stalls for the whole sweep. Coefficient memory is not cleared.
module steered_response_power_spectrum_top
  import srp_pkg::*;
#(
  parameter int NUM_BINS     = 257,
  parameter int NUM_CHANNELS = 8,
  parameter int NUM_ANGLES   = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  srp_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output srp_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  `include "steered_response_power_spectrum_top_defines.svh"

  localparam int Depth = NUM_ANGLES * NUM_BINS * NUM_CHANNELS;
  localparam int TabW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ChW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  srp_state_e state_q, state_d;

  logic        mode_q;
  logic [3:0]  chans_q;
  logic [5:0]  first_q;
  logic [6:0]  count_q;

  logic [8:0]  bin_q;
  logic [39:0] energy_q;
  logic [4:0]  nch_q;
  logic [8:0]  cur_q, stop_q;
  logic [4:0]  chan_q;
  logic [2:0]  step_q;
  logic signed [36:0] acc_re_q, acc_im_q;
  logic signed [41:0] prod_q;
  logic [40:0] pwr_q;
  srp_out_t    out_q;
  logic [31:0] smp_q [NUM_CHANNELS];

  logic        in_acc, out_acc;
  logic [4:0]  nch, ch_ext;
  logic        trig;
  logic [8:0]  stop_sum, stop_lim, stop_val;
  logic        is_last;
  logic [TabW-1:0] wr_addr, rd_addr;
  logic [31:0] coef, smp;
  logic signed [20:0] mul_a, mul_b, fa, fb;
  logic        mac_end;

  srp_ds_req_t  ds_req;
  srp_ds_stat_t ds_stat;
  logic [27:0]  ds_root;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Effective channel count and trigger decode
  always_comb begin
    if (chans_q == 4'd0) begin
      nch = 5'd1;
    end else if ({1'b0, chans_q} > 5'(NUM_CHANNELS)) begin
      nch = 5'(NUM_CHANNELS);
    end else begin
      nch = {1'b0, chans_q};
    end
    ch_ext = {2'b00, in_data_i.channel};
    trig = (in_data_i.func == FUNC_SAMPLE) && (ch_ext < 5'(NUM_CHANNELS))
        && (ch_ext == nch - 5'd1) && (32'(in_data_i.bin) < NUM_BINS)
        && (32'(first_q) < NUM_ANGLES) && (count_q != 7'd0);
    stop_sum = {3'b000, first_q} + {2'b00, count_q};
    stop_lim = {3'b000, first_q} + 9'(MaxResults);
    stop_val = stop_sum;
    if (32'(stop_val) > NUM_ANGLES) stop_val = 9'(NUM_ANGLES);
    if (stop_val > stop_lim) stop_val = stop_lim;
  end

  assign is_last = (cur_q + 9'd1 == stop_q);
  assign mac_end = (step_q == 3'd4);

  // Table addresses
  assign wr_addr = TabW'((32'(in_data_i.angle) * NUM_BINS + 32'(in_data_i.bin))
                         * NUM_CHANNELS + 32'(in_data_i.channel));
  assign rd_addr = TabW'((32'(cur_q) * NUM_BINS + 32'(bin_q)) * NUM_CHANNELS
                         + 32'(chan_q));

  srp_coef_ram #(
    .Depth (Depth),
    .AddrW (TabW)
  ) u_coef_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && in_data_i.func == FUNC_LOAD
                && 32'(in_data_i.angle) < NUM_ANGLES
                && 32'(in_data_i.bin) < NUM_BINS
                && 32'(in_data_i.channel) < NUM_CHANNELS),
    .wr_addr_i (wr_addr),
    .wr_data_i ({in_data_i.value_im, in_data_i.value_re}),
    .rd_addr_i (rd_addr),
    .rd_data_o (coef)
  );

  // Store channel samples
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.func == FUNC_SAMPLE && ch_ext < 5'(NUM_CHANNELS)) begin
      smp_q[ch_ext[ChW-1:0]] <= {in_data_i.value_im, in_data_i.value_re};
    end
  end

  assign smp = smp_q[chan_q[ChW-1:0]];
  assign fa  = 21'(acc_re_q >>> 15);
  assign fb  = 21'(acc_im_q >>> 15);

  // Select multiplier operands
  always_comb begin
    mul_a = fa;
    mul_b = fa;
    if (state_q == S_MAC) begin
      case (step_q)
        3'd0: begin
          mul_a = 21'(signed'(smp[15:0]));
          mul_b = 21'(signed'(coef[15:0]));
        end
        3'd1: begin
          mul_a = 21'(signed'(smp[31:16]));
          mul_b = 21'(signed'(coef[31:16]));
        end
        3'd2: begin
          mul_a = 21'(signed'(smp[31:16]));
          mul_b = 21'(signed'(coef[15:0]));
        end
        default: begin
          mul_a = 21'(signed'(smp[15:0]));
          mul_b = 21'(signed'(coef[31:16]));
        end
      endcase
    end else if (step_q != 3'd0) begin
      mul_a = fb;
      mul_b = fb;
    end
  end

  // Start the normalizer
  always_comb begin
    ds_req.start = (state_q == S_FIN) && mode_q && (energy_q != 40'd0);
    ds_req.num   = {pwr_q[39:0], 16'd0};
    ds_req.den   = energy_q;
  end

  srp_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .stat_o (ds_stat),
    .root_o (ds_root)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && trig) state_d = S_READ;
      S_READ: state_d = S_MAC;
      S_MAC:  if (mac_end) state_d = (chan_q + 5'd1 == nch_q) ? S_PWR : S_READ;
      S_PWR:  if (step_q == 3'd2) state_d = S_FIN;
      S_FIN:  state_d = ds_req.start ? S_NORM : S_OUT;
      S_NORM: if (ds_stat.done) state_d = S_OUT;
      S_OUT:  if (out_acc) state_d = is_last ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    out_data_o  = out_q;
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
      chans_q <= 4'd8;
      first_q <= 6'd0;
      count_q <= 7'd1;
      step_q  <= '0;
      chan_q  <= '0;
      cur_q   <= '0;
      stop_q  <= '0;
      nch_q   <= 5'd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:  mode_q  <= cfg_data_i[0];
          CFG_CHANS: chans_q <= cfg_data_i[3:0];
          CFG_FIRST: first_q <= cfg_data_i[5:0];
          CFG_COUNT: count_q <= cfg_data_i;
          default:   mode_q  <= mode_q;
        endcase
      end
      if (state_q != state_d) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 3'd1;
      end
      if (state_q == S_IDLE && in_acc && trig) begin
        cur_q  <= {3'b000, first_q};
        stop_q <= stop_val;
        nch_q  <= nch;
        chan_q <= '0;
      end else if (state_q == S_MAC && mac_end) begin
        chan_q <= chan_q + 5'd1;
      end else if (out_acc) begin
        cur_q  <= cur_q + 9'd1;
        chan_q <= '0;
      end
    end
  end

  // Multiply, accumulate and form the result
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == S_IDLE || out_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (state_q == S_MAC) begin
      case (step_q)
        3'd1: acc_re_q <= acc_re_q + prod_q[36:0];
        3'd2: acc_re_q <= acc_re_q + prod_q[36:0];
        3'd3: acc_im_q <= acc_im_q + prod_q[36:0];
        3'd4: acc_im_q <= acc_im_q - prod_q[36:0];
        default: acc_im_q <= acc_im_q;
      endcase
    end
    if (state_q == S_IDLE && in_acc && trig) begin
      bin_q    <= in_data_i.bin;
      energy_q <= in_data_i.energy;
    end
    if (state_q == S_PWR && step_q == 3'd1) begin
      pwr_q <= prod_q[40:0];
    end else if (state_q == S_PWR && step_q == 3'd2) begin
      pwr_q <= pwr_q + prod_q[40:0];
    end
    if (state_q == S_FIN) begin
      out_q.out_angle   <= cur_q[5:0];
      out_q.last        <= is_last;
      out_q.zero_energy <= mode_q;
      out_q.spectrum    <= mode_q ? SpecMax : (pwr_q[40] ? SpecMax : pwr_q[39:0]);
    end else if (state_q == S_NORM && ds_stat.done) begin
      out_q.zero_energy <= 1'b0;
      out_q.spectrum    <= {12'd0, ds_root};
    end
  end

  `SRP_ASSERT_NOW(a_no_accept_with_result, out_valid_o, in_stall_o, "input accepted while result pending")
  `SRP_ASSERT_NOW(a_ds_done_in_norm, ds_stat.done, state_q == S_NORM, "normalizer done outside wait")
  `SRP_ASSERT_NOW(a_zero_only_mode1, out_valid_o && out_data_o.zero_energy, mode_q, "zero energy flag in raw mode")
  `SRP_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i, state_q == S_OUT, "result dropped while stalled")

endmodule

// File: tb/tb_steered_response_power_spectrum_top.sv
// ----------------------------------------------------------------------------
// Steered response power spectrum testbench
// Loads coefficient tables for two bins and runs directed, then random,
// channel-sample sequences under several register settings. Every output
// beat is checked against an in-bench beamformer model. Both handshake
// sides get random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_steered_response_power_spectrum_top;
  import srp_pkg::*;

  localparam int NBins   = 257;
  localparam int NChans  = 8;
  localparam int NAngles = 64;
  localparam int LoadFirst = 61;
  localparam int CycleLimit = 3000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  srp_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  srp_out_t   out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_MODE;
  logic [6:0] cfg_data_i = '0;

  steered_response_power_spectrum_top uut (.*);

  always #10 clk_i = ~clk_i;

  // Bench copy of block state
  logic [31:0] coef_mem [int];
  logic [31:0] chan_word [NChans];
  logic        mode_q = 1'b0;
  logic [3:0]  chans_q = 4'd8;
  logic [5:0]  first_q = '0;
  logic [6:0]  count_q = 7'd1;

  srp_in_t  pending_beats [$];
  srp_out_t expected_bins [$];
  int errors = 0;
  int sweeps = 0;
  int beats_out = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Update the state copy and queue the beats one accepted input causes
  function automatic void predict_spectrum(srp_in_t b);
    int nch, stop, a, c;
    longint signed fa, fb, wr, wi, xr, xi;
    longint unsigned pwr, spec;
    logic [31:0] w, x;
    srp_out_t r;
    if (b.func == FUNC_LOAD) begin
      if (b.bin < NBins) coef_mem[(b.angle * NBins + b.bin) * NChans + b.channel] =
          {b.value_im, b.value_re};
      return;
    end
    chan_word[b.channel] = {b.value_im, b.value_re};
    nch = (chans_q == 0) ? 1 : (chans_q > NChans) ? NChans : chans_q;
    if (b.channel != nch - 1 || b.bin >= NBins) return;
    stop = first_q + count_q;
    if (stop > NAngles) stop = NAngles;
    if (stop > first_q + MaxResults) stop = first_q + MaxResults;
    if (stop > first_q) sweeps++;
    for (a = first_q; a < stop; a++) begin
      fa = 0;
      fb = 0;
      for (c = 0; c < nch; c++) begin
        w = coef_mem[(a * NBins + b.bin) * NChans + c];
        x = chan_word[c];
        wr = $signed(w[15:0]);
        wi = $signed(w[31:16]);
        xr = $signed(x[15:0]);
        xi = $signed(x[31:16]);
        fa += xr * wr + xi * wi;
        fb += xi * wr - xr * wi;
      end
      fa = fa >>> 15;
      fb = fb >>> 15;
      pwr = fa * fa + fb * fb;
      r.zero_energy = 1'b0;
      if (!mode_q) begin
        spec = (pwr > SpecMax) ? SpecMax : pwr;
      end else if (b.energy == 0) begin
        spec = SpecMax;
        r.zero_energy = 1'b1;
      end else begin
        spec = int_sqrt((pwr << 16) / b.energy);
        if (spec > SpecMax) spec = SpecMax;
      end
      r.out_angle = a[5:0];
      r.spectrum = spec[39:0];
      r.last = (a + 1 == stop);
      expected_bins.push_back(r);
    end
  endfunction

  // Input driver: hold a beat until accepted, then idle for a drawn gap
  int gap_left = 0;
  always @(posedge clk_i) begin
    bit busy;
    busy = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_spectrum(in_data_i);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
          gap_left <= in_burst ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each accepted beat, then stall for a drawn count
  int stall_left = 0;
  always @(posedge clk_i) begin
    int nxt;
    srp_out_t e;
    nxt = stall_left;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (expected_bins.size() == 0) begin
          $error("unexpected output beat angle %0d", out_data_o.out_angle);
          errors++;
        end else begin
          e = expected_bins.pop_front();
          if (e.out_angle !== out_data_o.out_angle) begin
            $error("out_angle exp %0d got %0d", e.out_angle, out_data_o.out_angle);
            errors++;
          end
          if (e.spectrum !== out_data_o.spectrum) begin
            $error("spectrum exp %0d got %0d", e.spectrum, out_data_o.spectrum);
            errors++;
          end
          if (e.zero_energy !== out_data_o.zero_energy) begin
            $error("zero_energy exp %0d got %0d", e.zero_energy, out_data_o.zero_energy);
            errors++;
          end
          if (e.last !== out_data_o.last) begin
            $error("last exp %0d got %0d", e.last, out_data_o.last);
            errors++;
          end
        end
        if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
        nxt = out_burst ? 0 : $urandom_range(0, 7);
      end else if (nxt > 0) begin
        nxt = nxt - 1;
      end
      stall_left <= nxt;
      out_stall_i <= (nxt != 0);
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic srp_in_t mk_beat(logic f, int ang, int bn, int ch,
                                       logic [15:0] re, logic [15:0] im,
                                       logic [39:0] en);
    srp_in_t b;
    b.func = f;
    b.angle = ang[5:0];
    b.bin = bn[8:0];
    b.channel = ch[2:0];
    b.value_re = re;
    b.value_im = im;
    b.energy = en;
    return b;
  endfunction

  function automatic logic [39:0] rand_energy();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 40'd1 + $urandom_range(0, 255);
      2: return {8'($urandom), 32'($urandom)};
      default: return 40'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  int loaded_bins [2] = '{0, 256};

  function automatic int pick_bin();
    if ($urandom_range(0, 5) == 0) return $urandom_range(NBins, 511);
    return loaded_bins[$urandom_range(0, 1)];
  endfunction

  // Samples for every active channel of one bin, ending on the trigger
  task automatic add_sweep(int bn, logic [39:0] en);
    int nch;
    nch = (chans_q == 0) ? 1 : (chans_q > NChans) ? NChans : chans_q;
    for (int c = 0; c < nch; c++)
      pending_beats.push_back(mk_beat(FUNC_SAMPLE, $urandom_range(0, 63), bn, c,
                                      16'($urandom), 16'($urandom), en));
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_bins.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_regs(logic m, logic [3:0] ch, logic [5:0] fa, logic [6:0] cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_MODE; cfg_data_i <= {6'd0, m};
    @(posedge clk_i);
    cfg_idx_i <= CFG_CHANS; cfg_data_i <= {3'd0, ch};
    @(posedge clk_i);
    cfg_idx_i <= CFG_FIRST; cfg_data_i <= {1'b0, fa};
    @(posedge clk_i);
    cfg_idx_i <= CFG_COUNT; cfg_data_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m; chans_q = ch; first_q = fa; count_q = cnt;
  endtask

  // Every phase sweeps only the loaded top angles
  logic [1:0]  ph_mode  [7] = '{0, 1, 0, 1, 0, 1, 1};
  logic [3:0]  ph_chans [7] = '{1, 0, 15, 3, 5, 8, 2};
  logic [5:0]  ph_first [7] = '{63, 62, 61, 62, 61, 63, 61};
  logic [6:0]  ph_count [7] = '{64, 0, 5, 1, 3, 30, 127};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Keep sweeps on the loaded angles before any sample arrives
    set_regs(1'b0, 4'd8, 6'd62, 7'd2);

    // Fill the coefficient table for the bins and angles used by sweeps
    foreach (loaded_bins[i])
      for (int a = LoadFirst; a < NAngles; a++)
        for (int c = 0; c < NChans; c++)
          pending_beats.push_back(mk_beat(FUNC_LOAD, a, loaded_bins[i], c,
                                          16'($urandom), 16'($urandom), '0));
    // Directed: extreme values, out-of-range loads and bins
    for (int c = 0; c < NChans; c++)
      pending_beats.push_back(mk_beat(FUNC_SAMPLE, 63, 0, c, 16'h7FFF, 16'h7FFF,
                                      {40{1'b1}}));
    for (int c = 0; c < NChans; c++)
      pending_beats.push_back(mk_beat(FUNC_SAMPLE, 0, 256, c, 16'h8000, 16'h8000, '0));
    pending_beats.push_back(mk_beat(FUNC_LOAD, 63, 400, 7, 16'h8000, 16'h7FFF, '0));
    pending_beats.push_back(mk_beat(FUNC_SAMPLE, 0, 300, 7, 16'h1234, 16'hFEDC, '0));
    drain();

    // Normalized mode, sweep clamped at the last angle: zero, maximal, unit energy
    set_regs(1'b1, 4'd8, 6'(LoadFirst), 7'd64);
    pending_beats.push_back(mk_beat(FUNC_SAMPLE, 0, 256, 7, 16'h8000, 16'h8000, '0));
    pending_beats.push_back(mk_beat(FUNC_SAMPLE, 0, 0, 7, 16'h7FFF, 16'h8000,
                                    {40{1'b1}}));
    pending_beats.push_back(mk_beat(FUNC_SAMPLE, 0, 256, 7, 16'h7FFF, 16'h7FFF, 40'd1));
    drain();

    // Random phases across register settings
    for (int p = 0; p < 7; p++) begin
      set_regs(ph_mode[p][0], ph_chans[p], ph_first[p], ph_count[p]);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0: pending_beats.push_back(mk_beat(FUNC_LOAD, $urandom_range(0, 63),
                                             $urandom_range(0, 511), $urandom_range(0, 7),
                                             16'($urandom), 16'($urandom), '0));
          1: pending_beats.push_back(mk_beat(FUNC_SAMPLE, $urandom_range(0, 63),
                                             pick_bin(), $urandom_range(0, 7),
                                             16'($urandom), 16'($urandom),
                                             rand_energy()));
          default: add_sweep(pick_bin(), rand_energy());
        endcase
      end
      drain();
    end

    $display("Covered %0d angle sweeps and %0d output beats over 9 register settings",
             sweeps, beats_out);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
